[rtl/r16dec_pkg.sv]
package r16dec_pkg;

    // Instruction formats, from bits 2:0
    typedef enum logic [2:0] {
        FMT_R   = 3'd0,
        FMT_I   = 3'd1,
        FMT_B   = 3'd2,
        FMT_S   = 3'd3,
        FMT_L   = 3'd4,
        FMT_J   = 3'd5,
        FMT_U   = 3'd6,
        FMT_SYS = 3'd7
    } t_format;

    // R-type keys: {bits 15:12, bits 5:3}
    localparam logic [6:0] R_KEY_ADD  = 7'h00;
    localparam logic [6:0] R_KEY_SUB  = 7'h08;
    localparam logic [6:0] R_KEY_SLT  = 7'h11;
    localparam logic [6:0] R_KEY_SLTU = 7'h1A;
    localparam logic [6:0] R_KEY_SLL  = 7'h23;
    localparam logic [6:0] R_KEY_SRL  = 7'h2B;
    localparam logic [6:0] R_KEY_SRA  = 7'h33;
    localparam logic [6:0] R_KEY_OR   = 7'h3C;
    localparam logic [6:0] R_KEY_AND  = 7'h45;
    localparam logic [6:0] R_KEY_XOR  = 7'h4E;
    localparam logic [6:0] R_KEY_MV   = 7'h57;
    localparam logic [6:0] R_KEY_JR   = 7'h58;
    localparam logic [6:0] R_KEY_JALR = 7'h60;

    // Operation indices, numbered per format
    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_SLT   = 4'd2;
    localparam logic [3:0] OP_SLTU  = 4'd3;
    localparam logic [3:0] OP_SLL   = 4'd4;
    localparam logic [3:0] OP_SRL   = 4'd5;
    localparam logic [3:0] OP_SRA   = 4'd6;
    localparam logic [3:0] OP_OR    = 4'd7;
    localparam logic [3:0] OP_AND   = 4'd8;
    localparam logic [3:0] OP_XOR   = 4'd9;
    localparam logic [3:0] OP_MV    = 4'd10;
    localparam logic [3:0] OP_JR    = 4'd11;
    localparam logic [3:0] OP_JALR  = 4'd12;

    localparam logic [3:0] OP_ADDI  = 4'd0;
    localparam logic [3:0] OP_SLTI  = 4'd1;
    localparam logic [3:0] OP_SLTUI = 4'd2;
    localparam logic [3:0] OP_SLLI  = 4'd3;
    localparam logic [3:0] OP_SRLI  = 4'd4;
    localparam logic [3:0] OP_SRAI  = 4'd5;
    localparam logic [3:0] OP_ORI   = 4'd6;
    localparam logic [3:0] OP_ANDI  = 4'd7;
    localparam logic [3:0] OP_XORI  = 4'd8;
    localparam logic [3:0] OP_LI    = 4'd9;

    localparam logic [3:0] OP_SB    = 4'd0;
    localparam logic [3:0] OP_SW    = 4'd1;
    localparam logic [3:0] OP_LB    = 4'd0;
    localparam logic [3:0] OP_LW    = 4'd1;
    localparam logic [3:0] OP_LBU   = 4'd2;
    localparam logic [3:0] OP_ECALL = 4'd0;
    localparam logic [3:0] OP_NONE  = 4'd0;

    // I-type function codes (bits 5:3)
    localparam logic [2:0] I_F3_ADDI  = 3'd0;
    localparam logic [2:0] I_F3_SLTI  = 3'd1;
    localparam logic [2:0] I_F3_SLTUI = 3'd2;
    localparam logic [2:0] I_F3_SHIFT = 3'd3;
    localparam logic [2:0] I_F3_ORI   = 3'd4;
    localparam logic [2:0] I_F3_ANDI  = 3'd5;
    localparam logic [2:0] I_F3_XORI  = 3'd6;
    localparam logic [2:0] I_F3_LI    = 3'd7;

    // Shift type, bits 15:13 of an I-type shift
    localparam logic [2:0] SHT_SRL = 3'b010;
    localparam logic [2:0] SHT_SRA = 3'b100;

    // S, L and SYS function codes
    localparam logic [2:0] S_F3_SB    = 3'd0;
    localparam logic [2:0] S_F3_SW    = 3'd1;
    localparam logic [2:0] L_F3_LB    = 3'd0;
    localparam logic [2:0] L_F3_LW    = 3'd1;
    localparam logic [2:0] L_F3_LBU   = 3'd4;
    localparam logic [2:0] SYS_F3_ECALL = 3'd0;

    localparam int unsigned INSTR_W = 16;
    localparam int unsigned RES_W   = 33;
    localparam int unsigned TDATA_W = 40;

    typedef struct packed {
        logic [15:0] immediate;
        logic [2:0]  src2_reg;
        logic [2:0]  src1_reg;
        logic [2:0]  dest_reg;
        logic        op_known;
        logic [3:0]  operation;
        t_format     format;
    } t_decoded;

endpackage

[rtl/r16dec_decode.sv]
module r16dec_decode (
    input  logic [15:0]          i_instruction,
    output r16dec_pkg::t_decoded o_decoded
);
    import r16dec_pkg::*;

    logic [2:0] w_f3;
    logic [2:0] w_ra;
    logic [2:0] w_rb;
    logic [3:0] w_hi4;
    logic [6:0] w_rkey;

    assign w_f3   = i_instruction[5:3];
    assign w_ra   = i_instruction[8:6];
    assign w_rb   = i_instruction[11:9];
    assign w_hi4  = i_instruction[15:12];
    assign w_rkey = {w_hi4, w_f3};

    // Field extraction per format
    always_comb begin
        o_decoded           = '0;
        o_decoded.format    = t_format'(i_instruction[2:0]);
        o_decoded.operation = OP_NONE;
        unique case (t_format'(i_instruction[2:0]))
            FMT_R: begin
                o_decoded.dest_reg = w_ra;
                o_decoded.src1_reg = w_ra;
                o_decoded.src2_reg = w_rb;
                o_decoded.op_known = 1'b1;
                unique case (w_rkey)
                    R_KEY_ADD:  o_decoded.operation = OP_ADD;
                    R_KEY_SUB:  o_decoded.operation = OP_SUB;
                    R_KEY_SLT:  o_decoded.operation = OP_SLT;
                    R_KEY_SLTU: o_decoded.operation = OP_SLTU;
                    R_KEY_SLL:  o_decoded.operation = OP_SLL;
                    R_KEY_SRL:  o_decoded.operation = OP_SRL;
                    R_KEY_SRA:  o_decoded.operation = OP_SRA;
                    R_KEY_OR:   o_decoded.operation = OP_OR;
                    R_KEY_AND:  o_decoded.operation = OP_AND;
                    R_KEY_XOR:  o_decoded.operation = OP_XOR;
                    R_KEY_MV:   o_decoded.operation = OP_MV;
                    R_KEY_JR:   o_decoded.operation = OP_JR;
                    R_KEY_JALR: o_decoded.operation = OP_JALR;
                    default: begin
                        o_decoded.operation = OP_NONE;
                        o_decoded.op_known  = 1'b0;
                    end
                endcase
            end
            FMT_I: begin
                o_decoded.dest_reg  = w_ra;
                o_decoded.src1_reg  = w_ra;
                o_decoded.op_known  = 1'b1;
                o_decoded.immediate = {{9{i_instruction[15]}}, i_instruction[15:9]};
                unique case (w_f3)
                    I_F3_ADDI:  o_decoded.operation = OP_ADDI;
                    I_F3_SLTI:  o_decoded.operation = OP_SLTI;
                    I_F3_SLTUI: o_decoded.operation = OP_SLTUI;
                    I_F3_SHIFT: begin
                        // shift amount is zero-extended; other type bits mean SLLI
                        o_decoded.immediate = {12'd0, i_instruction[12:9]};
                        if (i_instruction[15:13] == SHT_SRL) begin
                            o_decoded.operation = OP_SRLI;
                        end else if (i_instruction[15:13] == SHT_SRA) begin
                            o_decoded.operation = OP_SRAI;
                        end else begin
                            o_decoded.operation = OP_SLLI;
                        end
                    end
                    I_F3_ORI:   o_decoded.operation = OP_ORI;
                    I_F3_ANDI:  o_decoded.operation = OP_ANDI;
                    I_F3_XORI:  o_decoded.operation = OP_XORI;
                    I_F3_LI:    o_decoded.operation = OP_LI;
                    default:    o_decoded.operation = OP_NONE;
                endcase
            end
            FMT_B: begin
                o_decoded.src1_reg  = w_ra;
                o_decoded.src2_reg  = w_rb;
                o_decoded.op_known  = 1'b1;
                o_decoded.operation = {1'b0, w_f3};
                o_decoded.immediate = {{11{w_hi4[3]}}, w_hi4, 1'b0};
            end
            FMT_S: begin
                o_decoded.src1_reg  = w_ra;
                o_decoded.src2_reg  = w_rb;
                o_decoded.immediate = {{12{w_hi4[3]}}, w_hi4};
                if (w_f3 == S_F3_SB) begin
                    o_decoded.operation = OP_SB;
                    o_decoded.op_known  = 1'b1;
                end else if (w_f3 == S_F3_SW) begin
                    o_decoded.operation = OP_SW;
                    o_decoded.op_known  = 1'b1;
                end
            end
            FMT_L: begin
                o_decoded.dest_reg  = w_ra;
                o_decoded.src2_reg  = w_rb;
                o_decoded.immediate = {{12{w_hi4[3]}}, w_hi4};
                if (w_f3 == L_F3_LB) begin
                    o_decoded.operation = OP_LB;
                    o_decoded.op_known  = 1'b1;
                end else if (w_f3 == L_F3_LW) begin
                    o_decoded.operation = OP_LW;
                    o_decoded.op_known  = 1'b1;
                end else if (w_f3 == L_F3_LBU) begin
                    o_decoded.operation = OP_LBU;
                    o_decoded.op_known  = 1'b1;
                end
            end
            FMT_J: begin
                o_decoded.dest_reg  = w_ra;
                o_decoded.op_known  = 1'b1;
                o_decoded.operation = {3'd0, i_instruction[15]};
                o_decoded.immediate = {{6{i_instruction[14]}}, i_instruction[14:9],
                                       w_f3, 1'b0};
            end
            FMT_U: begin
                o_decoded.dest_reg  = w_ra;
                o_decoded.op_known  = 1'b1;
                o_decoded.operation = {3'd0, i_instruction[15]};
                o_decoded.immediate = {i_instruction[14:9], w_f3, 7'd0};
            end
            FMT_SYS: begin
                // syscall number, zero-extended
                o_decoded.immediate = {6'd0, i_instruction[15:6]};
                if (w_f3 == SYS_F3_ECALL) begin
                    o_decoded.operation = OP_ECALL;
                    o_decoded.op_known  = 1'b1;
                end
            end
            default: o_decoded.op_known = 1'b0;
        endcase
    end

endmodule

[rtl/risc16_instruction_decoder_core.sv]
// Decodes one 16-bit instruction per beat into format, operation index, a known
// flag, register fields and a 16-bit immediate. One beat is taken every cycle
// while the receiver accepts; each beat passes the input register, decode logic
// and the result register, and both stages hold under back-pressure so no beat
// is lost. Output tdata, lowest bit up: format[2:0], operation[6:3],
// op_known[7], dest_reg[10:8], src1_reg[13:11], src2_reg[16:14],
// immediate[32:17], zero fill [39:33].
module risc16_instruction_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side: tdata = instruction[15:0]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    // master side: tdata = format, operation, op_known, dest_reg, src1_reg,
    // src2_reg, immediate, zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata
);
    import r16dec_pkg::*;

    logic                r_in_valid;
    logic [INSTR_W-1:0]  r_instr;
    logic                r_out_valid;
    t_decoded            r_result;
    t_decoded            w_decoded;
    logic                w_out_ready;
    logic                w_in_ready;

    // stage moves when the next one is empty or being drained
    assign w_out_ready   = !r_out_valid || m_axis_tready;
    assign w_in_ready    = !r_in_valid || w_out_ready;
    assign s_axis_tready = w_in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && s_axis_tvalid) begin
            r_instr <= s_axis_tdata;
        end
    end

    r16dec_decode u_decode (
        .i_instruction (r_instr),
        .o_decoded     (w_decoded)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready && r_in_valid) begin
            r_result <= w_decoded;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(TDATA_W - RES_W){1'b0}}, r_result};

endmodule

[verif/risc16_instruction_decoder_core_test.sv]
`timescale 1ns / 100ps

module risc16_instruction_decoder_core_test;
    import r16dec_pkg::*;

    localparam int RUN_LIMIT  = 200000;
    localparam int RAND_ITEMS = 850;
    localparam int DRAIN_WAIT = 10;
    localparam int HOLD_AFTER = 300;
    localparam int HOLD_LEN   = 80;
    localparam int CALM_TAIL  = 120;

    localparam logic [6:0] R_KEY_LIST [13] = '{
        R_KEY_ADD, R_KEY_SUB, R_KEY_SLT, R_KEY_SLTU, R_KEY_SLL, R_KEY_SRL, R_KEY_SRA,
        R_KEY_OR, R_KEY_AND, R_KEY_XOR, R_KEY_MV, R_KEY_JR, R_KEY_JALR
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // instruction[15:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // format, operation, op_known, dest_reg, src1_reg, src2_reg, immediate, zero fill
    logic [39:0] m_axis_tdata;

    logic [15:0] pending_instrs [$];
    t_decoded    decoded_due [$];

    int   instrs_taken = 0;
    int   results_seen = 0;
    int   mismatches = 0;
    int   send_gap = 0;
    int   sink_gap = 0;
    bit   beat_taken = 1'b0;
    bit   hold_off = 1'b0;
    bit   no_idle = 1'b0;

    risc16_instruction_decoder_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Decoded form of one instruction word
    function automatic t_decoded decode_instruction(logic [15:0] w);
        t_decoded   d;
        logic [2:0] fn;
        logic [2:0] ra;
        logic [2:0] rb;
        logic [3:0] hi4;
        d   = '0;
        fn  = w[5:3];
        ra  = w[8:6];
        rb  = w[11:9];
        hi4 = w[15:12];
        d.format = t_format'(w[2:0]);
        case (d.format)
            FMT_R: begin
                d.dest_reg = ra;
                d.src1_reg = ra;
                d.src2_reg = rb;
                d.op_known = 1'b1;
                case ({hi4, fn})
                    R_KEY_ADD:  d.operation = OP_ADD;
                    R_KEY_SUB:  d.operation = OP_SUB;
                    R_KEY_SLT:  d.operation = OP_SLT;
                    R_KEY_SLTU: d.operation = OP_SLTU;
                    R_KEY_SLL:  d.operation = OP_SLL;
                    R_KEY_SRL:  d.operation = OP_SRL;
                    R_KEY_SRA:  d.operation = OP_SRA;
                    R_KEY_OR:   d.operation = OP_OR;
                    R_KEY_AND:  d.operation = OP_AND;
                    R_KEY_XOR:  d.operation = OP_XOR;
                    R_KEY_MV:   d.operation = OP_MV;
                    R_KEY_JR:   d.operation = OP_JR;
                    R_KEY_JALR: d.operation = OP_JALR;
                    default: begin
                        d.operation = OP_NONE;
                        d.op_known  = 1'b0;
                    end
                endcase
            end
            FMT_I: begin
                d.dest_reg = ra;
                d.src1_reg = ra;
                d.op_known = 1'b1;
                if (fn == I_F3_SHIFT) begin
                    // shift type from the top bits, anything unlisted is a left shift
                    case (w[15:13])
                        SHT_SRL: d.operation = OP_SRLI;
                        SHT_SRA: d.operation = OP_SRAI;
                        default: d.operation = OP_SLLI;
                    endcase
                    d.immediate = {12'd0, w[12:9]};
                end else begin
                    case (fn)
                        I_F3_ADDI:  d.operation = OP_ADDI;
                        I_F3_SLTI:  d.operation = OP_SLTI;
                        I_F3_SLTUI: d.operation = OP_SLTUI;
                        I_F3_ORI:   d.operation = OP_ORI;
                        I_F3_ANDI:  d.operation = OP_ANDI;
                        I_F3_XORI:  d.operation = OP_XORI;
                        default:    d.operation = OP_LI;
                    endcase
                    d.immediate = {{9{w[15]}}, w[15:9]};
                end
            end
            FMT_B: begin
                d.src1_reg  = ra;
                d.src2_reg  = rb;
                d.operation = {1'b0, fn};
                d.op_known  = 1'b1;
                d.immediate = {{11{hi4[3]}}, hi4, 1'b0};
            end
            FMT_S: begin
                d.src1_reg = ra;
                d.src2_reg = rb;
                if (fn == S_F3_SB) begin
                    d.operation = OP_SB;
                    d.op_known  = 1'b1;
                end else if (fn == S_F3_SW) begin
                    d.operation = OP_SW;
                    d.op_known  = 1'b1;
                end
                d.immediate = {{12{hi4[3]}}, hi4};
            end
            FMT_L: begin
                d.dest_reg = ra;
                d.src2_reg = rb;
                d.op_known = 1'b1;
                case (fn)
                    L_F3_LB:  d.operation = OP_LB;
                    L_F3_LW:  d.operation = OP_LW;
                    L_F3_LBU: d.operation = OP_LBU;
                    default:  d.op_known  = 1'b0;
                endcase
                d.immediate = {{12{hi4[3]}}, hi4};
            end
            FMT_J: begin
                d.dest_reg  = ra;
                d.op_known  = 1'b1;
                d.operation = {3'd0, w[15]};
                d.immediate = {{6{w[14]}}, w[14:9], fn, 1'b0};
            end
            FMT_U: begin
                d.dest_reg  = ra;
                d.op_known  = 1'b1;
                d.operation = {3'd0, w[15]};
                d.immediate = {w[14:9], fn, 7'd0};
            end
            default: begin
                if (fn == SYS_F3_ECALL) begin
                    d.operation = OP_ECALL;
                    d.op_known  = 1'b1;
                end
                d.immediate = {6'd0, w[15:6]};
            end
        endcase
        return d;
    endfunction

    // Instruction driver: a new beat only once the current one has gone
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= 0;
        end else if (!s_axis_tvalid || beat_taken) begin
            if (send_gap != 0) begin
                s_axis_tvalid <= 1'b0;
                send_gap      <= send_gap - 1;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                s_axis_tvalid <= 1'b0;
                send_gap      <= $urandom_range(0, 11);
            end else if (pending_instrs.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_instrs.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result sink with random stalls, plus the long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_gap      <= 0;
        end else if (hold_off) begin
            m_axis_tready <= 1'b0;
        end else if (sink_gap != 0) begin
            m_axis_tready <= 1'b0;
            sink_gap      <= sink_gap - 1;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            sink_gap      <= $urandom_range(0, 11);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: predict on each input beat, check each output beat in order
    always @(posedge i_clk) begin
        t_decoded want;
        t_decoded got;
        beat_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                decoded_due.push_back(decode_instruction(s_axis_tdata));
                instrs_taken <= instrs_taken + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_decoded'(m_axis_tdata[RES_W-1:0]);
                results_seen <= results_seen + 1;
                if (decoded_due.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result beat, tdata=%h", $realtime, m_axis_tdata);
                end else begin
                    want = decoded_due.pop_front();
                    if (got.format !== want.format || got.operation !== want.operation ||
                        got.op_known !== want.op_known || got.dest_reg !== want.dest_reg ||
                        got.src1_reg !== want.src1_reg || got.src2_reg !== want.src2_reg ||
                        got.immediate !== want.immediate) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10) begin
                            $display("%0t: expected fmt=%0d op=%0d known=%0d rd=%0d rs1=%0d rs2=%0d imm=%h",
                                     $realtime, want.format, want.operation, want.op_known,
                                     want.dest_reg, want.src1_reg, want.src2_reg, want.immediate);
                            $display("%0t:   actual fmt=%0d op=%0d known=%0d rd=%0d rs1=%0d rs2=%0d imm=%h",
                                     $realtime, got.format, got.operation, got.op_known,
                                     got.dest_reg, got.src1_reg, got.src2_reg, got.immediate);
                        end
                    end
                end
            end
        end
    end

    // Long receiver hold-off once traffic is flowing, so the input stalls
    initial begin
        while (instrs_taken < HOLD_AFTER) @(negedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_LEN) @(negedge i_clk);
        hold_off = 1'b0;
    end

    // Watchdog
    initial begin
        repeat (RUN_LIMIT) @(posedge i_clk);
        $display("risc16_instruction_decoder_core regression: fail");
        $finish;
    end

    // Stimulus and end of run
    initial begin
        logic [15:0] word;
        int          n_total;

        // directed: extremes, every format, shift types and unlisted encodings
        pending_instrs.push_back({R_KEY_ADD[6:3], 3'd0, 3'd0, R_KEY_ADD[2:0], FMT_R});
        pending_instrs.push_back({R_KEY_JALR[6:3], 3'd7, 3'd7, R_KEY_JALR[2:0], FMT_R});
        pending_instrs.push_back({4'hF, 3'd5, 3'd2, 3'd7, FMT_R});
        pending_instrs.push_back({7'h3F, 3'd1, I_F3_ADDI, FMT_I});
        pending_instrs.push_back({7'h40, 3'd7, I_F3_LI, FMT_I});
        pending_instrs.push_back({SHT_SRL, 4'hF, 3'd3, I_F3_SHIFT, FMT_I});
        pending_instrs.push_back({SHT_SRA, 4'h0, 3'd4, I_F3_SHIFT, FMT_I});
        pending_instrs.push_back({3'b111, 4'hA, 3'd6, I_F3_SHIFT, FMT_I});
        pending_instrs.push_back({4'h7, 3'd1, 3'd2, 3'd0, FMT_B});
        pending_instrs.push_back({4'h8, 3'd6, 3'd5, 3'd7, FMT_B});
        pending_instrs.push_back({4'h7, 3'd3, 3'd4, S_F3_SB, FMT_S});
        pending_instrs.push_back({4'h8, 3'd7, 3'd0, S_F3_SW, FMT_S});
        pending_instrs.push_back({4'hF, 3'd2, 3'd1, 3'd2, FMT_S});
        pending_instrs.push_back({4'h7, 3'd0, 3'd7, L_F3_LB, FMT_L});
        pending_instrs.push_back({4'h8, 3'd7, 3'd0, L_F3_LW, FMT_L});
        pending_instrs.push_back({4'hF, 3'd5, 3'd3, L_F3_LBU, FMT_L});
        pending_instrs.push_back({4'h0, 3'd1, 3'd6, 3'd7, FMT_L});
        pending_instrs.push_back({1'b0, 6'h1F, 3'd2, 3'd7, FMT_J});
        pending_instrs.push_back({1'b1, 6'h20, 3'd5, 3'd0, FMT_J});
        pending_instrs.push_back({1'b0, 6'h3F, 3'd7, 3'd7, FMT_U});
        pending_instrs.push_back({1'b1, 6'h00, 3'd0, 3'd0, FMT_U});
        pending_instrs.push_back({10'h3FF, SYS_F3_ECALL, FMT_SYS});
        pending_instrs.push_back({10'h3FF, 3'd7, FMT_SYS});

        // random words, half of them steered onto listed encodings
        for (int n = 0; n < RAND_ITEMS; n++) begin
            word = 16'($urandom);
            if ($urandom_range(0, 1) == 0) begin
                case (t_format'(word[2:0]))
                    FMT_R: {word[15:12], word[5:3]} = R_KEY_LIST[$urandom_range(0, 12)];
                    FMT_I: begin
                        if ($urandom_range(0, 1) == 0) begin
                            word[5:3] = I_F3_SHIFT;
                            case ($urandom_range(0, 2))
                                0: word[15:13] = SHT_SRL;
                                1: word[15:13] = SHT_SRA;
                                default: ;
                            endcase
                        end
                    end
                    FMT_S: word[5:3] = ($urandom_range(0, 1) == 0) ? S_F3_SB : S_F3_SW;
                    FMT_L: begin
                        case ($urandom_range(0, 2))
                            0: word[5:3] = L_F3_LB;
                            1: word[5:3] = L_F3_LW;
                            default: word[5:3] = L_F3_LBU;
                        endcase
                    end
                    FMT_SYS: word[5:3] = SYS_F3_ECALL;
                    default: ;
                endcase
            end
            pending_instrs.push_back(word);
        end
        n_total = pending_instrs.size();

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // no idling on either side for the tail of the run
        while (pending_instrs.size() > CALM_TAIL) @(posedge i_clk);
        no_idle = 1'b1;

        while (instrs_taken != n_total || results_seen != instrs_taken) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (decoded_due.size() != 0)
            $display("%0t: %0d expected results never arrived", $realtime, decoded_due.size());
        if (mismatches == 0 && decoded_due.size() == 0)
            $display("risc16_instruction_decoder_core regression: pass");
        else
            $display("risc16_instruction_decoder_core regression: fail");
        $finish;
    end

endmodule

[filelist.f]
rtl/r16dec_pkg.sv
rtl/r16dec_decode.sv
rtl/risc16_instruction_decoder_core.sv
verif/risc16_instruction_decoder_core_test.sv
